// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by the top-level RTL file, which carries the checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property check that also runs during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/chfxy_pkg.sv =====
// Shared constants and the arctangent table for the compass heading block.
// No dependencies.
package chfxy_pkg;

   localparam int DATA_WIDTH_DEF      = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 6;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int GUARD_BITS   = 16;
   localparam int ACC_FRAC     = 20;
   localparam int ACC_WIDTH    = 31;
   localparam int TABLE_LEN    = 24;
   localparam int HEADING_BITS = 15;
   localparam int QUEUE_DEPTH  = 4;
   localparam int ADDR_WIDTH   = 3;

   localparam logic [14:0] DEAD_ZONE_RESET = 15'd26;

   // Register indexes (byte address divided by four).
   localparam logic REG_DEAD_ZONE = 1'b0;

   // atan(2^-i) in degrees scaled by 2^20, rounded to nearest.
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ACC_WIDTH-1:0] r;
      case (idx)
         5'd0:  r = 31'sd47185920;
         5'd1:  r = 31'sd27855475;
         5'd2:  r = 31'sd14718068;
         5'd3:  r = 31'sd7471121;
         5'd4:  r = 31'sd3750058;
         5'd5:  r = 31'sd1876857;
         5'd6:  r = 31'sd938658;
         5'd7:  r = 31'sd469357;
         5'd8:  r = 31'sd234682;
         5'd9:  r = 31'sd117342;
         5'd10: r = 31'sd58671;
         5'd11: r = 31'sd29335;
         5'd12: r = 31'sd14668;
         5'd13: r = 31'sd7334;
         5'd14: r = 31'sd3667;
         5'd15: r = 31'sd1833;
         5'd16: r = 31'sd917;
         5'd17: r = 31'sd458;
         5'd18: r = 31'sd229;
         5'd19: r = 31'sd115;
         5'd20: r = 31'sd57;
         5'd21: r = 31'sd29;
         5'd22: r = 31'sd14;
         5'd23: r = 31'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/compass_heading_from_xy_top.sv =====
// Top level of the compass heading block: configuration register, front end,
// request queue and CORDIC back end. Depends on chfxy_pkg and all chfxy modules.

// Returns heading = atan2(-y, -x) in 1/64 degree units for each x,y request,
// one result per request, in order. A new request is taken every cycle while
// req_stall is low. An accepted request loads the front-end register, then
// enters the queue, passes one CORDIC stage per iteration (at most 24) and
// reaches the result register. A four-entry queue between the front end and
// the CORDIC pipeline absorbs stalls. The dead_zone register sits at byte
// address 0 and resets to 26 (about 0.1 in Q8.8); a value of 0 acts as 1.
`include "assert_macros.svh"

module compass_heading_from_xy_top import chfxy_pkg::*; #(
   parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [DATA_WIDTH-1:0]   req_field_x,
   input  logic signed [DATA_WIDTH-1:0]   req_field_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [HEADING_BITS-1:0] rsp_heading,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ADDR_WIDTH-1:0]          paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int W  = DATA_WIDTH + GUARD_BITS + 3;
   localparam int QW = 2 * W + ACC_WIDTH;

   logic [DATA_WIDTH-2:0]       dead_zone_ff, dead_zone_in;
   logic                        f_valid, q_full, q_not_empty, q_pop;
   logic signed [W-1:0]         f_a, f_b;
   logic signed [ACC_WIDTH-1:0] f_z;
   logic [QW-1:0]               q_out;
   logic [$clog2(QUEUE_DEPTH):0] q_count;

   // Configuration register.
   assign pready = 1'b1;
   always_comb begin
      dead_zone_in = dead_zone_ff;
      if (psel && penable && pwrite && paddr[2] == REG_DEAD_ZONE) begin
         dead_zone_in = pwdata[DATA_WIDTH-2:0];
      end
      prdata = (paddr[2] == REG_DEAD_ZONE) ? 32'(dead_zone_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= (DATA_WIDTH-1)'(DEAD_ZONE_RESET);
      end else begin
         dead_zone_ff <= dead_zone_in;
      end
   end

   chfxy_front #(.DATA_WIDTH(DATA_WIDTH), .W(W)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_field_x, .req_field_y,
      .dead_zone(dead_zone_ff), .q_full,
      .out_valid(f_valid), .out_a(f_a), .out_b(f_b), .out_z(f_z)
   );

   chfxy_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(f_valid), .push_data({f_a, f_b, f_z}), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .not_empty(q_not_empty), .count(q_count)
   );

   chfxy_back #(
      .DATA_WIDTH(DATA_WIDTH), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .CORDIC_STEPS(CORDIC_STEPS), .W(W)
   ) u_back (
      .clock, .reset, .in_valid(q_not_empty), .in_pop(q_pop),
      .in_a(signed'(q_out[QW-1 -: W])), .in_b(signed'(q_out[ACC_WIDTH +: W])),
      .in_z(signed'(q_out[ACC_WIDTH-1:0])),
      .rsp_valid, .rsp_stall, .rsp_heading
   );

   `CHK_ASSERT(a_heading_range, clock, reset, rsp_valid |-> (rsp_heading <= 15'sd11520 && rsp_heading >= -15'sd11520) || ANGLE_FRAC_BITS != 6, "heading out of range")
   `CHK_ASSERT(a_queue_bound, clock, reset, q_count <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH), "queue overfilled")
   `CHK_ASSERT(a_stall_needs_full, clock, reset, req_stall |-> q_full && f_valid, "front stalls without a full queue")
   `CHK_ASSERT(a_pop_not_empty, clock, reset, q_pop |-> q_not_empty, "pop from empty queue")

endmodule

// ===== hdl/chfxy_front.sv =====
// Front end: accepts a request, applies the dead zone and folds the vector
// into the right half-plane. Depends on chfxy_pkg.
module chfxy_front import chfxy_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int W          = DATA_WIDTH + GUARD_BITS + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_field_x,
   input  logic signed [DATA_WIDTH-1:0] req_field_y,
   input  logic [DATA_WIDTH-2:0]        dead_zone,
   input  logic                         q_full,
   output logic                         out_valid,
   output logic signed [W-1:0]          out_a,
   output logic signed [W-1:0]          out_b,
   output logic signed [ACC_WIDTH-1:0]  out_z
);

   logic                        valid_ff, valid_in;
   logic signed [W-1:0]         a_ff, a_in, b_ff, b_in;
   logic signed [ACC_WIDTH-1:0] z_ff, z_in;
   logic                        adv;
   logic [DATA_WIDTH-2:0]       dz_eff;
   logic signed [DATA_WIDTH:0]  dze, xs, ys, xc, yc;
   logic signed [W-1:0]         ax, bx;

   // Register is free or its request moves into the queue.
   assign adv       = !valid_ff || !q_full;
   assign req_stall = valid_ff && q_full;

   // Dead zone, negation and half-plane fold.
   always_comb begin
      dz_eff = (dead_zone == '0) ? {{(DATA_WIDTH-2){1'b0}}, 1'b1} : dead_zone;
      dze    = signed'({2'b00, dz_eff});
      xs     = signed'({req_field_x[DATA_WIDTH-1], req_field_x});
      ys     = signed'({req_field_y[DATA_WIDTH-1], req_field_y});
      xc     = (xs < dze && xs > -dze) ? dze : xs;
      yc     = (ys < dze && ys > -dze) ? dze : ys;
      ax     = -(signed'({{(W-DATA_WIDTH-1){xc[DATA_WIDTH]}}, xc}) <<< GUARD_BITS);
      bx     = -(signed'({{(W-DATA_WIDTH-1){yc[DATA_WIDTH]}}, yc}) <<< GUARD_BITS);
      a_in   = ax;
      b_in   = bx;
      z_in   = '0;
      if (ax[W-1]) begin
         z_in = bx[W-1] ? -(ACC_WIDTH'(180) <<< ACC_FRAC) : (ACC_WIDTH'(180) <<< ACC_FRAC);
         a_in = -ax;
         b_in = -bx;
      end
      valid_in = adv ? req_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && req_valid) begin
         a_ff <= a_in;
         b_ff <= b_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_z     = z_ff;

endmodule

// ===== hdl/chfxy_queue.sv =====
// Short request queue between the front end and the CORDIC back end.
// Depends on chfxy_pkg.
module chfxy_queue import chfxy_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic [$clog2(QUEUE_DEPTH):0] count
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ff];
   assign count     = cnt_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/chfxy_back.sv =====
// Back end: pipelined CORDIC vectoring stages, rounding, saturation and the
// result register. Depends on chfxy_pkg.
module chfxy_back import chfxy_pkg::*; #(
   parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int W               = DATA_WIDTH + GUARD_BITS + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_pop,
   input  logic signed [W-1:0]           in_a,
   input  logic signed [W-1:0]           in_b,
   input  logic signed [ACC_WIDTH-1:0]   in_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [HEADING_BITS-1:0] rsp_heading
);

   localparam int N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

   logic                        v_ff [N];
   logic signed [W-1:0]         a_ff [N];
   logic signed [W-1:0]         b_ff [N];
   logic signed [ACC_WIDTH-1:0] z_ff [N];
   logic signed [W-1:0]         a_in [N];
   logic signed [W-1:0]         b_in [N];
   logic signed [ACC_WIDTH-1:0] z_in [N];

   logic                         en;
   logic                         out_valid_ff, out_valid_in;
   logic signed [HEADING_BITS-1:0] heading_ff, heading_in;
   logic signed [ACC_WIDTH:0]    zr, h, lim;

   // The whole pipeline advances unless a finished result is held.
   assign en     = !(out_valid_ff && rsp_stall);
   assign in_pop = en && in_valid;

   // One CORDIC rotation per stage.
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [W-1:0]         sa, sb;
      logic signed [ACC_WIDTH-1:0] sz;
      if (i == 0) begin : g_first
         assign sa = in_a;
         assign sb = in_b;
         assign sz = in_z;
      end else begin : g_next
         assign sa = a_ff[i-1];
         assign sb = b_ff[i-1];
         assign sz = z_ff[i-1];
      end
      always_comb begin
         if (!sb[W-1]) begin
            a_in[i] = sa + (sb >>> i);
            b_in[i] = sb - (sa >>> i);
            z_in[i] = sz + atan_entry(5'(i));
         end else begin
            a_in[i] = sa - (sb >>> i);
            b_in[i] = sb + (sa >>> i);
            z_in[i] = sz - atan_entry(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[i] <= a_in[i];
            b_ff[i] <= b_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   // Round to the output scale and clamp to plus or minus 180 degrees.
   always_comb begin
      zr  = {z_ff[N-1][ACC_WIDTH-1], z_ff[N-1]} + ((ACC_WIDTH+1)'(1) <<< (SHIFT-1));
      h   = zr >>> SHIFT;
      lim = (ACC_WIDTH+1)'(180) <<< ANGLE_FRAC_BITS;
      if (h > lim) begin
         h = lim;
      end else if (h < -lim) begin
         h = -lim;
      end
      heading_in   = h[HEADING_BITS-1:0];
      out_valid_in = en ? v_ff[N-1] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_heading = heading_ff;

endmodule

// ===== test/testbench.sv =====
// Testbench for compass_heading_from_xy_top: sends x,y requests, predicts each
// heading with its own CORDIC model and checks results in order. Depends on chfxy_pkg.
`timescale 1ns / 1ps

module testbench import chfxy_pkg::*;;

   localparam int STEPS     = CORDIC_STEPS_DEF;
   localparam int SETTLE    = STEPS + 3 + QUEUE_DEPTH + 8;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } xy_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [15:0]             req_field_x = '0;
   logic signed [15:0]             req_field_y = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [HEADING_BITS-1:0] rsp_heading;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0]          paddr = '0;
   logic [31:0]                    pwdata = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   // Our copy of the threshold register and the pending headings.
   logic [14:0]       dz_reg = DEAD_ZONE_RESET;
   logic [14:0]       heading_fifo[$];
   int                send_gap_pct = 0;
   int                sink_stall_pct = 0;
   int                cycles = 0;
   bit                failed = 1'b0;

   longint atan_q20[24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7};

   compass_heading_from_xy_top dut (.*);

   always #1 clock = ~clock;

   // Fixed-point heading: dead zone, half-plane flip, CORDIC, round, saturate.
   function automatic logic [14:0] heading_of(logic signed [15:0] fx,
                                              logic signed [15:0] fy,
                                              logic [14:0] dzr);
      longint xv, yv, dz, a, b, z, da, db, h;
      xv = fx;
      yv = fy;
      dz = (dzr == 0) ? 1 : dzr;
      z  = 0;
      if (xv < dz && xv > -dz) xv = dz;
      if (yv < dz && yv > -dz) yv = dz;
      a = -xv * 65536;
      b = -yv * 65536;
      if (a < 0) begin
         z = (b >= 0) ? 180 * 1048576 : -180 * 1048576;
         a = -a;
         b = -b;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         da = a >>> i;
         db = b >>> i;
         if (b >= 0) begin
            a = a + db;
            b = b - da;
            z = z + atan_q20[i];
         end else begin
            a = a - db;
            b = b + da;
            z = z - atan_q20[i];
         end
      end
      h = (z + (64'sd1 <<< 13)) >>> 14;
      if (h > 11520) h = 11520;
      if (h < -11520) h = -11520;
      return h[14:0];
   endfunction

   // Random field: mostly full range, some near the threshold, some axes.
   function automatic logic signed [15:0] pick_field();
      int sel;
      int span;
      sel  = $urandom_range(9);
      span = 2 * ((dz_reg == 0) ? 1 : int'(dz_reg)) + 2;
      if (sel < 6) return $urandom;
      if (sel < 9) return $urandom_range(2 * span) - span;
      return 0;
   endfunction

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("compass_heading_from_xy_top: mismatch");
         $finish;
      end
   end

   // Result side stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (heading_fifo.size() == 0) begin
            $display("%0t: unexpected heading %0d", $time, rsp_heading);
            failed = 1'b1;
         end else begin
            if (rsp_heading !== heading_fifo[0]) begin
               $display("%0t: heading expected %0d got %0d", $time,
                        $signed(heading_fifo[0]), rsp_heading);
               failed = 1'b1;
            end
            void'(heading_fifo.pop_front());
         end
      end
   end

   // Send one request; called and returns at a falling edge.
   task automatic send_xy(logic signed [15:0] fx, logic signed [15:0] fy);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_field_x <= fx;
      req_field_y <= fy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      heading_fifo.push_back(heading_of(fx, fy, dz_reg));
      @(negedge clock);
   endtask

   // Wait for all results, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (heading_fifo.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Register write: setup cycle then access cycle.
   task automatic write_dead_zone(logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_WIDTH'(REG_DEAD_ZONE) << 2;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      dz_reg  = value[14:0];
   endtask

   task automatic random_phase(int count, int gap, int stall);
      send_gap_pct   = gap;
      sink_stall_pct = stall;
      repeat (count) send_xy(pick_field(), pick_field());
      drain();
   endtask

   xy_row_type directed[] = '{
      '{16'sd0, 16'sd0}, '{16'sd32767, 16'sd32767}, '{-16'sd32768, -16'sd32768},
      '{16'sd32767, -16'sd32768}, '{-16'sd32768, 16'sd32767},
      '{16'sd25, -16'sd25}, '{16'sd26, 16'sd26}, '{-16'sd26, -16'sd26},
      '{-16'sd25, 16'sd0}, '{16'sd256, 16'sd0}, '{-16'sd256, 16'sd0},
      '{16'sd0, 16'sd256}, '{16'sd0, -16'sd256}, '{16'sd256, 16'sd1},
      '{16'sd256, -16'sd256}, '{16'sd32767, 16'sd0}, '{-16'sd32768, 16'sd0},
      '{16'sd100, -16'sd27}, '{-16'sd27, 16'sd100}, '{16'sd32767, -16'sd1}};

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests at the reset threshold, with no idling.
      foreach (directed[i]) send_xy(directed[i].x, directed[i].y);
      drain();

      // Zero threshold acts as one; upper data bits must be ignored.
      write_dead_zone(32'hFFFF_0000);
      random_phase(320, 23, 63);
      write_dead_zone(32'h0000_7FFF);
      random_phase(320, 63, 23);
      write_dead_zone(32'd1);
      foreach (directed[i]) send_xy(directed[i].x, directed[i].y);
      write_dead_zone_idle: begin
         drain();
         write_dead_zone({$urandom} & 32'hFFFF_FFFF);
      end
      random_phase(310, 0, 0);

      if (!failed)
         $display("compass_heading_from_xy_top: match");
      else
         $display("compass_heading_from_xy_top: mismatch");
      $finish;
   end

endmodule
